@@ rtl/core/spn128_pkg.sv @@
// Shared types, constants, S-boxes and round helper functions for the SPN block cipher.
package spn128_pkg;

  localparam int unsigned BLK_W      = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned KEY_IDX_W  = 4;
  localparam int unsigned NUM_ROUNDS = 10;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

  localparam logic [HALF_W-1:0] KEY_RESET = 64'h1234567812345678;

  localparam logic [KEY_IDX_W-1:0] LAST_KEY_IDX = KEY_IDX_W'(NUM_ROUNDS);

  typedef enum logic [1:0] {
    OP_ROUND = 2'd0,
    OP_LAST  = 2'd1,
    OP_XOR   = 2'd2
  } spn128_op_e;

  typedef struct packed {
    logic       load;
    logic       step;
    spn128_op_e op;
    logic       inv;
    logic       flip;
  } spn128_ctrl_t;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [BLK_W-1:0] spn128_transpose(input logic [BLK_W-1:0] blk);
    logic [BLK_W-1:0] res;
    res = '0;
    for (int j = 0; j < 16; j++) begin
      res[BLK_W-1-8*j -: 8] = blk[BLK_W-1-8*(4*(j & 3) + (j >> 2)) -: 8];
    end
    return res;
  endfunction

  function automatic logic [7:0] spn128_rcon(input logic [KEY_IDX_W-1:0] idx);
    logic [7:0] rc;
    case (idx)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  function automatic logic [BLK_W-1:0] spn128_key_next(input logic [BLK_W-1:0] k,
                                                       input logic [KEY_IDX_W-1:0] idx);
    logic [WORD_W-1:0] rot;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] n0;
    logic [WORD_W-1:0] n1;
    logic [WORD_W-1:0] n2;
    logic [WORD_W-1:0] n3;
    rot = {k[23:0], k[31:24]};
    t   = {SBOX_FWD[rot[31:24]], SBOX_FWD[rot[23:16]],
           SBOX_FWD[rot[15:8]], SBOX_FWD[rot[7:0]]} ^ {spn128_rcon(idx), 24'h000000};
    n0  = k[127:96] ^ t;
    n1  = k[95:64] ^ n0;
    n2  = k[63:32] ^ n1;
    n3  = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

@@ rtl/core/spn128_key_unit.sv @@
// Key registers, iterative key expander and round key store.
module spn128_key_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [spn128_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [spn128_pkg::HALF_W-1:0]          cfg_wdata_i,
  input  logic [spn128_pkg::KEY_IDX_W-1:0]       key_idx_i,
  output logic [spn128_pkg::BLK_W-1:0]           round_key_o,
  output logic                                   busy_o
);
  import spn128_pkg::*;

  logic [HALF_W-1:0]    key_high_q, key_high_d;
  logic [HALF_W-1:0]    key_low_q, key_low_d;
  logic [BLK_W-1:0]     cur_q, cur_d;
  logic [KEY_IDX_W-1:0] cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 hit;
  logic [BLK_W-1:0]     next_key;
  logic [BLK_W-1:0]     store_q [NUM_ROUNDS];

  always_comb begin
    key_high_d = key_high_q;
    key_low_d  = key_low_q;
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    run_d      = run_q;
    hit        = cfg_we_i && ((cfg_index_i == REG_KEY_HIGH) || (cfg_index_i == REG_KEY_LOW));
    next_key   = spn128_key_next(cur_q, cnt_q);
    if (cfg_we_i && (cfg_index_i == REG_KEY_HIGH)) begin
      key_high_d = cfg_wdata_i;
    end
    if (cfg_we_i && (cfg_index_i == REG_KEY_LOW)) begin
      key_low_d = cfg_wdata_i;
    end
    if (hit) begin
      cur_d = {key_high_d, key_low_d};
      cnt_d = KEY_IDX_W'(1);
      run_d = 1'b1;
    end else if (run_q) begin
      cur_d = next_key;
      cnt_d = cnt_q + KEY_IDX_W'(1);
      run_d = (cnt_q != LAST_KEY_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= KEY_RESET;
      key_low_q  <= KEY_RESET;
      cur_q      <= {KEY_RESET, KEY_RESET};
      cnt_q      <= KEY_IDX_W'(1);
      run_q      <= 1'b1;
    end else begin
      key_high_q <= key_high_d;
      key_low_q  <= key_low_d;
      cur_q      <= cur_d;
      cnt_q      <= cnt_d;
      run_q      <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q && !hit) begin
      store_q[cnt_q - KEY_IDX_W'(1)] <= next_key;
    end
  end

  assign round_key_o = (key_idx_i == '0) ? {key_high_q, key_low_q}
                                         : store_q[key_idx_i - KEY_IDX_W'(1)];
  assign busy_o      = run_q;

endmodule

@@ rtl/core/spn128_round_unit.sv @@
// Block state register and the shared key-add, substitution and transpose round logic.
module spn128_round_unit (
  input  logic                          clk_i,
  input  spn128_pkg::spn128_ctrl_t      ctrl_i,
  input  logic [spn128_pkg::BLK_W-1:0]  blk_i,
  input  logic [spn128_pkg::BLK_W-1:0]  key_i,
  output logic [spn128_pkg::BLK_W-1:0]  blk_o
);
  import spn128_pkg::*;

  logic [BLK_W-1:0] state_q, state_d;
  logic [BLK_W-1:0] mixed;
  logic [BLK_W-1:0] subbed;

  always_comb begin
    mixed = state_q ^ (ctrl_i.flip ? spn128_transpose(key_i) : key_i);
    for (int j = 0; j < 16; j++) begin
      subbed[8*j +: 8] = ctrl_i.inv ? SBOX_INV[mixed[8*j +: 8]] : SBOX_FWD[mixed[8*j +: 8]];
    end
    case (ctrl_i.op)
      OP_ROUND: state_d = spn128_transpose(subbed);
      OP_LAST:  state_d = subbed;
      OP_XOR:   state_d = mixed;
      default:  state_d = mixed;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      state_q <= blk_i;
    end else if (ctrl_i.step) begin
      state_q <= state_d;
    end
  end

  assign blk_o = state_q;

endmodule

@@ rtl/core/spn_block_cipher_128_unit.sv @@
// Operation: one shared round unit does 10 rounds and the final key add at one step per cycle;
// the result then moves into the output register once the output is free, and the next
// block is accepted only in the idle state after that.
// Reset: the key registers take their reset value and the round keys are expanded, with
// the input stalled; every key write repeats that expansion.
module spn_block_cipher_128_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [spn128_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spn128_pkg::HALF_W-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [spn128_pkg::HALF_W-1:0]       block_in_high_i,
  input  logic [spn128_pkg::HALF_W-1:0]       block_in_low_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [spn128_pkg::HALF_W-1:0]       block_out_high_o,
  output logic [spn128_pkg::HALF_W-1:0]       block_out_low_o
);
  import spn128_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam logic [KEY_IDX_W-1:0] LAST_ROUND_STEP = KEY_IDX_W'(NUM_ROUNDS - 1);

  state_e               state_q, state_d;
  logic [KEY_IDX_W-1:0] step_q, step_d;
  logic                 cmd_q, cmd_d;
  logic                 out_valid_q, out_valid_d;
  logic [HALF_W-1:0]    out_high_q;
  logic [HALF_W-1:0]    out_low_q;
  logic                 accept;
  logic                 out_free;
  logic                 key_busy;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [BLK_W-1:0]     round_key;
  logic [BLK_W-1:0]     blk_state;
  spn128_ctrl_t         ctrl;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE) || key_busy;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    key_idx   = cmd_q ? (LAST_KEY_IDX - step_q) : step_q;
    ctrl.load = accept;
    ctrl.step = (state_q == ST_RUN);
    ctrl.inv  = cmd_q;
    ctrl.flip = cmd_q && (key_idx != '0) && (key_idx != LAST_KEY_IDX);
    if (step_q == LAST_KEY_IDX) begin
      ctrl.op = OP_XOR;
    end else if (step_q == LAST_ROUND_STEP) begin
      ctrl.op = OP_LAST;
    end else begin
      ctrl.op = OP_ROUND;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          step_d  = '0;
          cmd_d   = command_i;
        end
      end
      ST_RUN: begin
        step_d = step_q + KEY_IDX_W'(1);
        if (step_q == LAST_KEY_IDX) begin
          state_d = ST_DONE;
          step_d  = '0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cmd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_high_q <= blk_state[BLK_W-1:HALF_W];
      out_low_q  <= blk_state[HALF_W-1:0];
    end
  end

  spn128_key_unit u_key (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_idx_i   (key_idx),
    .round_key_o (round_key),
    .busy_o      (key_busy)
  );

  spn128_round_unit u_round (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .blk_i  ({block_in_high_i, block_in_low_i}),
    .key_i  (round_key),
    .blk_o  (blk_state)
  );

  assign out_valid_o      = out_valid_q;
  assign block_out_high_o = out_high_q;
  assign block_out_low_o  = out_low_q;

`ifndef ASSERT_OFF
  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN) && (step_q == '0))
    else $error("accepted word did not start the round sequence");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= LAST_KEY_IDX))
    else $error("round step counter ran past the final key add");

  a_key_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && ((cfg_index_i == REG_KEY_HIGH) ||
     (cfg_index_i == REG_KEY_LOW))) |=> in_stall_o)
    else $error("input not stalled while round keys are expanded");

  a_done_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_free) |=> out_valid_o && (state_q == ST_IDLE))
    else $error("finished block was not moved to the output register");
`endif

endmodule
